/* sv/tilt_angle_and_bubble_position_top_defines.svh */
// Assertion macros shared by the tilt angle and bubble position block.
`ifndef TILT_ANGLE_AND_BUBBLE_POSITION_TOP_DEFINES_SVH
`define TILT_ANGLE_AND_BUBBLE_POSITION_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define TAB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tilt angle check failed");

// Checks that cons holds in the cycle after ante holds.
`define TAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tilt angle check failed");

`endif

/* sv/tab_pkg.sv */
// Types, constants and the arctangent table of the tilt angle block.
package tab_pkg;

  // Number of CORDIC cells; the table bounds it.
  localparam int CORDIC_STAGES = 20;
  localparam int TABLE_LEN     = 28;
  localparam int N_CELLS       = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int IDX_W         = $clog2(TABLE_LEN);

  // Datapath widths: magnitudes, CORDIC vector and angle accumulator.
  localparam int MAG_W   = 17;
  localparam int IN_SHIFT = 16;
  localparam int XY_W    = 35;
  localparam int ANG_W   = 32;
  localparam int FRAC_W  = 24;

  localparam logic signed [ANG_W-1:0] DEG45 = ANG_W'(45) <<< FRAC_W;
  localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(90) <<< FRAC_W;
  localparam logic signed [ANG_W:0]   DEG180 = (ANG_W+1)'(180) <<< FRAC_W;
  localparam logic [7:0] BUBBLE_CENTER = 8'd9;
  localparam logic [4:0] BUBBLE_MAX    = 5'd18;

  // Arctangent of 2^-i in degrees with 24 fraction bits.
  localparam logic signed [ANG_W-1:0] ATAN_TBL [TABLE_LEN] = '{
    32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
    32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
    32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
    32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
    32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
    32'sd917,       32'sd458,       32'sd229,       32'sd115,
    32'sd57,        32'sd29,        32'sd14,        32'sd7
  };

  // Input beat.
  typedef struct packed {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_z;
  } sample_t;

  // Result beat.
  typedef struct packed {
    logic signed [8:0] angle_deg;
    logic [4:0]        bubble_position;
  } result_t;

  // Quadrant and special-case flags that ride along the cell chain.
  typedef struct packed {
    logic neg_x;
    logic neg_z;
    logic zero_x;
    logic zero_z;
    logic equal;
    logic lt;
  } side_t;

  // State handed from cell to cell.
  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] a;
    side_t                   side;
  } cordic_t;

endpackage

/* sv/tilt_angle_and_bubble_position_top.sv */
// Top level of the tilt angle and bubble position block.
// Takes one X/Z accelerometer beat per clock cycle (busy is always low) and
// gives atan2(x, z) in whole degrees, truncated toward zero, with the level
// bubble index 9 + angle clamped to 0..18. Each result appears on done for one
// cycle once its start beat has passed one input register, one cell per CORDIC
// iteration in the chain, and one output register. The receiver cannot stall,
// so every result must be taken in the cycle it is shown; results come out in
// input order.
module tilt_angle_and_bubble_position_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tab_pkg::sample_t sample,
  output logic             done,
  output tab_pkg::result_t result
);
  import tab_pkg::*;

  logic    vld  [N_CELLS+1];
  cordic_t cord [N_CELLS+1];

  // The pipeline takes a beat every cycle.
  assign busy = 1'b0;

  tab_pre u_pre (
    .clk    (clk),
    .rst    (rst),
    .start  (start && !busy),
    .sample (sample),
    .vld    (vld[0]),
    .cord   (cord[0])
  );

  // Chain of CORDIC cells, cell g shifting by g.
  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    tab_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(g)),
      .vld_in   (vld[g]),
      .cord_in  (cord[g]),
      .vld_out  (vld[g+1]),
      .cord_out (cord[g+1])
    );
  end

  tab_post u_post (
    .clk    (clk),
    .rst    (rst),
    .vld    (vld[N_CELLS]),
    .cord   (cord[N_CELLS]),
    .done   (done),
    .result (result)
  );

endmodule

/* sv/tab_pre.sv */
// Input stage: axis magnitudes, quadrant flags and the CORDIC start vector.
module tab_pre (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tab_pkg::sample_t sample,
  output logic             vld,
  output tab_pkg::cordic_t cord
);
  import tab_pkg::*;

  logic signed [MAG_W-1:0] xs, zs;
  logic [MAG_W-1:0]        ax, az;
  cordic_t                 cord_next;

  // Magnitudes of both axes; the most negative sample needs the extra bit.
  always_comb begin
    xs = MAG_W'(sample.acc_x);
    zs = MAG_W'(sample.acc_z);
    ax = xs[MAG_W-1] ? MAG_W'(-xs) : MAG_W'(xs);
    az = zs[MAG_W-1] ? MAG_W'(-zs) : MAG_W'(zs);
    cord_next.x = $signed({{(XY_W-MAG_W-IN_SHIFT){1'b0}}, az, {IN_SHIFT{1'b0}}});
    cord_next.y = $signed({{(XY_W-MAG_W-IN_SHIFT){1'b0}}, ax, {IN_SHIFT{1'b0}}});
    cord_next.a = '0;
    cord_next.side.neg_x  = sample.acc_x[15];
    cord_next.side.neg_z  = sample.acc_z[15];
    cord_next.side.zero_x = (ax == '0);
    cord_next.side.zero_z = (az == '0);
    cord_next.side.equal  = (ax == az);
    cord_next.side.lt     = (ax < az);
  end

  // Valid flag is reset; the vector is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    cord <= cord_next;
  end

endmodule

/* sv/tab_cell.sv */
// One CORDIC vectoring cell: a single shift-add rotation per cycle.
module tab_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [tab_pkg::IDX_W-1:0] idx,
  input  logic                     vld_in,
  input  tab_pkg::cordic_t         cord_in,
  output logic                     vld_out,
  output tab_pkg::cordic_t         cord_out
);
  import tab_pkg::*;

  logic signed [XY_W-1:0] dx, dy;
  cordic_t                cord_next;

  // Rotate toward the x axis; the shifts round toward minus infinity.
  always_comb begin
    dx = cord_in.y >>> idx;
    dy = cord_in.x >>> idx;
    cord_next = cord_in;
    if (!cord_in.y[XY_W-1]) begin
      cord_next.x = cord_in.x + dx;
      cord_next.y = cord_in.y - dy;
      cord_next.a = cord_in.a + ATAN_TBL[idx];
    end else begin
      cord_next.x = cord_in.x - dx;
      cord_next.y = cord_in.y + dy;
      cord_next.a = cord_in.a - ATAN_TBL[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    cord_out <= cord_next;
  end

endmodule

/* sv/tab_post.sv */
// Output stage: angle clamping, quadrant fold, degree count and bubble index.
module tab_post (
  input  logic             clk,
  input  logic             rst,
  input  logic             vld,
  input  tab_pkg::cordic_t cord,
  output logic             done,
  output tab_pkg::result_t result
);
  import tab_pkg::*;

  `include "tilt_angle_and_bubble_position_top_defines.svh"

  logic signed [ANG_W-1:0] a_q1;
  logic signed [ANG_W:0]   a_fold;
  logic [7:0]              mag;
  result_t                 result_next;

  // First-quadrant angle: exact on the axes and the diagonal, else kept strictly inside those boundaries.
  always_comb begin
    a_q1 = cord.a;
    if (cord.side.zero_x) begin
      a_q1 = '0;
    end else if (cord.side.zero_z) begin
      a_q1 = DEG90;
    end else if (cord.side.equal) begin
      a_q1 = DEG45;
    end else if (cord.side.lt) begin
      if (cord.a < ANG_W'(1)) a_q1 = ANG_W'(1);
      if (cord.a > DEG45 - ANG_W'(1)) a_q1 = DEG45 - ANG_W'(1);
    end else begin
      if (cord.a < DEG45 + ANG_W'(1)) a_q1 = DEG45 + ANG_W'(1);
      if (cord.a > DEG90 - ANG_W'(1)) a_q1 = DEG90 - ANG_W'(1);
    end
  end

  // Fold into the half plane, take whole degrees, then apply the sign of x.
  always_comb begin
    a_fold = cord.side.neg_z ? (DEG180 - (ANG_W+1)'(a_q1)) : (ANG_W+1)'(a_q1);
    mag = a_fold[FRAC_W+7:FRAC_W];
    result_next.angle_deg = cord.side.neg_x ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (cord.side.neg_x) begin
      result_next.bubble_position = (mag >= BUBBLE_CENTER) ? 5'd0 : 5'(BUBBLE_CENTER - mag);
    end else begin
      result_next.bubble_position = (mag >= BUBBLE_CENTER) ? BUBBLE_MAX
                                                            : 5'(BUBBLE_CENTER + mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // The bubble index stays on the level line and follows the angle.
  `TAB_ASSERT_NOW(a_bubble_range, done, result.bubble_position <= BUBBLE_MAX)
  `TAB_ASSERT_NOW(a_angle_range, done,
                  (result.angle_deg >= -9'sd180) && (result.angle_deg <= 9'sd180))
  `TAB_ASSERT_NOW(a_bubble_right, done && (result.angle_deg > 9'sd9),
                  result.bubble_position == BUBBLE_MAX)
  `TAB_ASSERT_NEXT(a_zero_x, vld && cord.side.zero_x && !cord.side.neg_z,
                   result.angle_deg == 9'sd0)

endmodule
